/* rtl/core/nhr_ag_pkg.sv */
// shared types, constants and helpers of the all-gather step scheduler
`default_nettype none

package nhr_ag_pkg;

    // field widths
    localparam int unsigned RankW  = 7;
    localparam int unsigned PosW   = 6;
    localparam int unsigned StepW  = 3;
    localparam int unsigned CountW = 6;

    // at most this many slice results per step
    localparam logic [CountW-1:0] ResultLimit = 6'd32;

    // configuration register indexes
    typedef enum logic {
        REG_RANK_COUNT  = 1'b0,
        REG_MY_POSITION = 1'b1
    } reg_index_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic calc;
        logic emit;
        logic emit_err;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic step_err;
        logic div_last;
        logic out_free;
        logic last_slice;
    } dp_status_t;

    // number of doubling steps to cover n members: ceil(log2(n))
    function automatic logic [StepW-1:0] step_total(input logic [RankW-1:0] n);
        logic [StepW-1:0] s;
        s = '0;
        for (int i = 0; i < RankW; i++) begin
            if ((8'd1 << i) < {1'b0, n}) begin
                s = StepW'(i + 1);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/nhr_ag_cfg_regs.sv */
// apb register file holding group size and node position
`default_nettype none

module nhr_ag_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output logic      [nhr_ag_pkg::RankW-1:0] rank_count,
    output logic      [nhr_ag_pkg::PosW-1:0]  my_position
);

    logic [nhr_ag_pkg::RankW-1:0] rank_count_reg;
    logic [nhr_ag_pkg::PosW-1:0]  my_position_reg;
    nhr_ag_pkg::reg_index_t       index;
    logic                         wr_en;

    assign pready = 1'b1;
    assign index  = nhr_ag_pkg::reg_index_t'(paddr[2]);
    assign wr_en  = psel & penable & pwrite & pready;

    // register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_count_reg  <= nhr_ag_pkg::RankW'(1);
            my_position_reg <= '0;
        end else if (wr_en) begin
            unique case (index)
                nhr_ag_pkg::REG_RANK_COUNT:  rank_count_reg  <= pwdata[nhr_ag_pkg::RankW-1:0];
                nhr_ag_pkg::REG_MY_POSITION: my_position_reg <= pwdata[nhr_ag_pkg::PosW-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (index)
            nhr_ag_pkg::REG_RANK_COUNT:  prdata = 32'(rank_count_reg);
            nhr_ag_pkg::REG_MY_POSITION: prdata = 32'(my_position_reg);
            default:                     prdata = '0;
        endcase
    end

    assign rank_count  = rank_count_reg;
    assign my_position = my_position_reg;

endmodule

`default_nettype wire

/* rtl/core/nhr_ag_ctrl.sv */
// sequencing state machine of the step scheduler
`default_nettype none

module nhr_ag_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire nhr_ag_pkg::dp_status_t status,
    output nhr_ag_pkg::dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_CALC,
        ST_EMIT,
        ST_ERR
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.step_err ? ST_ERR : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_slice) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (status.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nhr_ag_dp.sv */
// datapath: position reduction, peers, slice walk and output register
`default_nettype none

module nhr_ag_dp #(
    parameter int MAX_RANKS = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [nhr_ag_pkg::RankW-1:0]  rank_count,
    input  wire logic [nhr_ag_pkg::PosW-1:0]   my_position,
    input  wire logic [nhr_ag_pkg::StepW-1:0]  step,
    input  wire nhr_ag_pkg::dp_cmd_t           cmd,
    output nhr_ag_pkg::dp_status_t             status,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [nhr_ag_pkg::PosW-1:0]        send_peer,
    output logic [nhr_ag_pkg::PosW-1:0]        recv_peer,
    output logic [nhr_ag_pkg::CountW-1:0]      slice_count,
    output logic [nhr_ag_pkg::PosW-1:0]        tx_slice,
    output logic [nhr_ag_pkg::PosW-1:0]        rx_slice,
    output logic                               last,
    output logic                               step_error
);

    localparam int unsigned RankW  = nhr_ag_pkg::RankW;
    localparam int unsigned PosW   = nhr_ag_pkg::PosW;
    localparam int unsigned StepW  = nhr_ag_pkg::StepW;
    localparam int unsigned CountW = nhr_ag_pkg::CountW;
    localparam logic [RankW:0] MaxRanks = (RankW+1)'(MAX_RANKS);

    // per-request registers
    logic [RankW-1:0]  n_reg;
    logic [StepW-1:0]  s_reg;
    logic [StepW-1:0]  step_reg;
    logic [PosW-1:0]   div_reg;
    logic [RankW-1:0]  pos_reg;
    logic [2:0]        div_cnt_reg;
    logic [RankW-1:0]  d2m_reg;
    logic [RankW-1:0]  sp_reg;
    logic [RankW-1:0]  rp_reg;
    logic [CountW-1:0] cnt_reg;
    logic [RankW-1:0]  tx_reg;
    logic [RankW-1:0]  rx_reg;
    logic [CountW-1:0] left_reg;

    // output register
    logic              out_valid_reg;
    logic [PosW-1:0]   send_peer_reg;
    logic [PosW-1:0]   recv_peer_reg;
    logic [CountW-1:0] slice_count_reg;
    logic [PosW-1:0]   tx_slice_reg;
    logic [PosW-1:0]   rx_slice_reg;
    logic              last_reg;
    logic              step_error_reg;

    logic [RankW-1:0]  n_eff;
    logic [RankW:0]    div_trial;
    logic [RankW-1:0]  div_rem_next;
    logic [RankW-1:0]  d;
    logic [RankW:0]    d2;
    logic [RankW:0]    sp_sum;
    logic [RankW:0]    rp_sum;
    logic [RankW:0]    cnt_num;
    logic [RankW:0]    cnt_raw;
    logic [RankW:0]    tx_sum;
    logic [RankW:0]    rx_sum;
    logic [RankW-1:0]  tx_next;
    logic [RankW-1:0]  rx_next;
    logic              out_free;

    // effective group size: zero reads as one, saturate at the maximum
    always_comb begin
        priority if (rank_count == '0) begin
            n_eff = RankW'(1);
        end else if ({1'b0, rank_count} > MaxRanks) begin
            n_eff = RankW'(MaxRanks);
        end else begin
            n_eff = rank_count;
        end
    end

    // one restoring step of position mod n
    assign div_trial    = {pos_reg, div_reg[PosW-1]};
    assign div_rem_next = (div_trial >= {1'b0, n_reg}) ?
                          RankW'(div_trial - {1'b0, n_reg}) : div_trial[RankW-1:0];

    // peer distance and derived values
    assign d       = RankW'(1) << (s_reg - step_reg - StepW'(1));
    assign d2      = {d, 1'b0};
    assign sp_sum  = {1'b0, pos_reg} + {1'b0, d};
    assign rp_sum  = {1'b0, pos_reg} + {1'b0, n_reg} - {1'b0, d};
    assign cnt_num = {1'b0, n_reg} - (RankW+1)'(1) + {1'b0, d};
    assign cnt_raw = cnt_num >> (s_reg - step_reg);

    // slice indices step down by twice the distance modulo n
    assign tx_sum  = {1'b0, tx_reg} + {1'b0, n_reg} - {1'b0, d2m_reg};
    assign rx_sum  = {1'b0, rx_reg} + {1'b0, n_reg} - {1'b0, d2m_reg};
    assign tx_next = (tx_sum >= {1'b0, n_reg}) ? RankW'(tx_sum - {1'b0, n_reg})
                                               : tx_sum[RankW-1:0];
    assign rx_next = (rx_sum >= {1'b0, n_reg}) ? RankW'(rx_sum - {1'b0, n_reg})
                                               : rx_sum[RankW-1:0];

    assign out_free = !out_valid_reg || out_ready;

    assign status.step_err   = (step_reg >= s_reg);
    assign status.div_last   = (div_cnt_reg == '0);
    assign status.out_free   = out_free;
    assign status.last_slice = (left_reg == CountW'(1));

    // request setup, reduction and schedule registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg       <= n_eff;
            s_reg       <= nhr_ag_pkg::step_total(n_eff);
            step_reg    <= step;
            div_reg     <= my_position;
            pos_reg     <= '0;
            div_cnt_reg <= 3'(PosW - 1);
        end
        if (cmd.div_step) begin
            pos_reg     <= div_rem_next;
            div_reg     <= {div_reg[PosW-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg - 3'd1;
        end
        if (cmd.calc) begin
            sp_reg   <= (sp_sum >= {1'b0, n_reg}) ? RankW'(sp_sum - {1'b0, n_reg})
                                                  : sp_sum[RankW-1:0];
            rp_reg   <= (rp_sum >= {1'b0, n_reg}) ? RankW'(rp_sum - {1'b0, n_reg})
                                                  : rp_sum[RankW-1:0];
            rx_reg   <= (rp_sum >= {1'b0, n_reg}) ? RankW'(rp_sum - {1'b0, n_reg})
                                                  : rp_sum[RankW-1:0];
            tx_reg   <= pos_reg;
            d2m_reg  <= (d2 >= {1'b0, n_reg}) ? RankW'(d2 - {1'b0, n_reg})
                                              : d2[RankW-1:0];
            if (cnt_raw > (RankW+1)'(nhr_ag_pkg::ResultLimit)) begin
                cnt_reg  <= nhr_ag_pkg::ResultLimit;
                left_reg <= nhr_ag_pkg::ResultLimit;
            end else begin
                cnt_reg  <= CountW'(cnt_raw);
                left_reg <= CountW'(cnt_raw);
            end
        end
        if (cmd.emit) begin
            tx_reg   <= tx_next;
            rx_reg   <= rx_next;
            left_reg <= left_reg - CountW'(1);
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            send_peer_reg   <= sp_reg[PosW-1:0];
            recv_peer_reg   <= rp_reg[PosW-1:0];
            slice_count_reg <= cnt_reg;
            tx_slice_reg    <= tx_reg[PosW-1:0];
            rx_slice_reg    <= rx_reg[PosW-1:0];
            last_reg        <= (left_reg == CountW'(1));
            step_error_reg  <= 1'b0;
        end else if (cmd.emit_err) begin
            send_peer_reg   <= '0;
            recv_peer_reg   <= '0;
            slice_count_reg <= '0;
            tx_slice_reg    <= '0;
            rx_slice_reg    <= '0;
            last_reg        <= 1'b1;
            step_error_reg  <= 1'b1;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_err) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign send_peer   = send_peer_reg;
    assign recv_peer   = recv_peer_reg;
    assign slice_count = slice_count_reg;
    assign tx_slice    = tx_slice_reg;
    assign rx_slice    = rx_slice_reg;
    assign last        = last_reg;
    assign step_error  = step_error_reg;

endmodule

`default_nettype wire

/* rtl/core/nhr_allgather_step_schedule.sv */
// all-gather step scheduler: for one step number, emits the exchange plan
//
// the host sets rank_count (offset 0) and my_position (offset 4) over apb
// while the block is idle. each transfer on the s_ stream carries a step
// number; the block answers on the m_ stream with one transfer per slice
// exchanged in that step (send/recv peers, slice count, tx and rx slice
// indices), tlast on the final one. a step at or beyond ceil(log2(n))
// gives a single transfer with tuser and tlast set and all data fields
// zero. after acceptance the request passes a check state, then the
// reduction of the position modulo n (one quotient bit per cycle) and a
// setup state, then gives one result per cycle while the receiver keeps
// up; an error request goes from the check state to an error state that
// gives the single error result. one request is handled at a time;
// s_tready is high only between requests, and may be high while the last
// result of the previous request still waits in the output register.
// when the receiver stalls, results hold in the output register and the
// walk pauses. reset returns rank_count = 1, my_position = 0 and an
// empty output register.
`default_nettype none

module nhr_allgather_step_schedule #(
    parameter int MAX_RANKS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [2:0] step
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [5:0] send_peer, [11:6] recv_peer,
                                        // [17:12] slice_count, [23:18] tx_slice,
                                        // [29:24] rx_slice
    output logic             m_tlast,
    output logic             m_tuser,   // [0] step_error
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [nhr_ag_pkg::RankW-1:0]  rank_count;
    logic [nhr_ag_pkg::PosW-1:0]   my_position;
    nhr_ag_pkg::dp_cmd_t           cmd;
    nhr_ag_pkg::dp_status_t        status;
    logic [nhr_ag_pkg::PosW-1:0]   send_peer;
    logic [nhr_ag_pkg::PosW-1:0]   recv_peer;
    logic [nhr_ag_pkg::CountW-1:0] slice_count;
    logic [nhr_ag_pkg::PosW-1:0]   tx_slice;
    logic [nhr_ag_pkg::PosW-1:0]   rx_slice;

    nhr_ag_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .rank_count  (rank_count),
        .my_position (my_position)
    );

    nhr_ag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nhr_ag_dp #(
        .MAX_RANKS (MAX_RANKS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rank_count  (rank_count),
        .my_position (my_position),
        .step        (s_tdata[nhr_ag_pkg::StepW-1:0]),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .send_peer   (send_peer),
        .recv_peer   (recv_peer),
        .slice_count (slice_count),
        .tx_slice    (tx_slice),
        .rx_slice    (rx_slice),
        .last        (m_tlast),
        .step_error  (m_tuser)
    );

    // pack result fields, lowest first
    assign m_tdata = {2'b00, rx_slice, tx_slice, slice_count, recv_peer, send_peer};

endmodule

`default_nettype wire
